// File: hw/rtl/msd_pkg.sv
package msd_pkg;

   // Display geometry.
   localparam int DEFAULT_NUM_DIGITS = 4;
   localparam int MAX_DIGITS         = 8;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Largest value that write number shows as decimal digits.
   localparam logic [14:0] NUMBER_LIMIT = 15'd9999;

   // Reciprocal constants for the decimal split of values up to the limit.
   localparam logic [13:0] RECIP_10   = 14'd13108;
   localparam int          SHIFT_10   = 17;
   localparam logic [13:0] RECIP_100  = 14'd10486;
   localparam int          SHIFT_100  = 20;
   localparam logic [13:0] RECIP_1000 = 14'd8389;
   localparam int          SHIFT_1000 = 23;

   // Command codes on the request channel.
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_CHAR   = 2'd1;
   localparam logic [1:0] CMD_NUMBER = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Segment bits, in shift order.
   localparam logic [7:0] SEG_B  = 8'h01;
   localparam logic [7:0] SEG_F  = 8'h02;
   localparam logic [7:0] SEG_A  = 8'h04;
   localparam logic [7:0] SEG_G  = 8'h08;
   localparam logic [7:0] SEG_C  = 8'h10;
   localparam logic [7:0] SEG_DP = 8'h20;
   localparam logic [7:0] SEG_D  = 8'h40;
   localparam logic [7:0] SEG_E  = 8'h80;
   localparam logic [7:0] SEG_BLANK = 8'h00;

   // Operation carried from the front to the back.
   typedef enum logic [1:0] {
      OP_TICK,
      OP_CHAR,
      OP_NUMBER,
      OP_ERROR
   } op_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [1:0]         position;
      logic [7:0]         character;
      logic signed [15:0] number;
   } req_type;

   typedef struct packed {
      logic [1:0] digit_index;
      logic [3:0] cathode_lines;
      logic [7:0] segment_pattern;
   } rsp_type;

   // One queue entry: the classified command and the decimal quotients.
   typedef struct packed {
      op_type      op;
      logic [1:0]  position;
      logic [7:0]  character;
      logic [13:0] value;
      logic [9:0]  tens;
      logic [6:0]  hundreds;
      logic [3:0]  thousands;
   } entry_type;

   // Segment byte for a character; unknown characters are blank.
   function automatic logic [7:0] glyph(input logic [7:0] ch);
      logic [7:0] seg;
      case (ch)
         "0": seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
         "1": seg = SEG_B | SEG_C;
         "2": seg = SEG_A | SEG_B | SEG_G | SEG_E | SEG_D;
         "3": seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
         "4": seg = SEG_F | SEG_B | SEG_C | SEG_G;
         "5": seg = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
         "6": seg = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D | SEG_E;
         "7": seg = SEG_A | SEG_B | SEG_C;
         "8": seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         "9": seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
         "A": seg = SEG_A | SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;
         "b": seg = SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         "C": seg = SEG_A | SEG_F | SEG_E | SEG_D;
         "d": seg = SEG_B | SEG_C | SEG_D | SEG_E | SEG_G;
         "E": seg = SEG_A | SEG_D | SEG_E | SEG_F | SEG_G;
         "F": seg = SEG_A | SEG_E | SEG_F | SEG_G;
         "L": seg = SEG_F | SEG_E | SEG_D;
         "o": seg = SEG_C | SEG_D | SEG_E | SEG_G;
         "c": seg = SEG_E | SEG_D | SEG_G;
         "H": seg = SEG_B | SEG_C | SEG_G | SEG_F | SEG_E;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

   // Power-up text: " Loc", with blanks beyond the fourth digit.
   function automatic logic [7:0] reset_char(input int pos);
      logic [7:0] ch;
      case (pos)
         1: ch = "L";
         2: ch = "o";
         3: ch = "c";
         default: ch = " ";
      endcase
      return ch;
   endfunction

endpackage

// File: hw/rtl/msd_chan_if.sv
interface msd_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

// File: hw/rtl/multiplexed_seven_segment_driver.sv
// Channel  Role    Payload
// req_chan sink    cmd, position, character, number
// rsp_chan source  digit_index, cathode_lines, segment_pattern (one beat per tick)
//
// One request beat is taken every cycle while the two-entry queue has room.
// A tick result passes through a queue entry and then the output register;
// character and number writes take effect when they leave the queue.
// Reset is synchronous: the text reads " Loc" and the last digit is selected.
// A stalled result holds ticks in the queue while writes ahead of them still drain;
// req_chan.ready falls only when both queue entries are occupied.
module multiplexed_seven_segment_driver #(
   parameter int NUM_DIGITS = msd_pkg::DEFAULT_NUM_DIGITS
) (
   input logic         clock,
   input logic         reset,
   msd_chan_if.sink    req_chan,
   msd_chan_if.source  rsp_chan
);
   import msd_pkg::*;

   logic      req_ready;
   logic      push;
   entry_type push_data;
   logic      push_ready;
   logic      pop_valid;
   entry_type pop_data;
   logic      pop;
   logic      rsp_valid;
   rsp_type   rsp_data;

   // Front: handshake and classification.
   msd_front u_front (
      .req_valid   (req_chan.valid),
      .req_data    (req_chan.data),
      .req_ready   (req_ready),
      .queue_ready (push_ready),
      .push        (push),
      .push_data   (push_data)
   );

   // Queue between the front and the back.
   msd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop)
   );

   // Back: text buffer, digit counter and result register.
   msd_back #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (pop_valid),
      .entry       (pop_data),
      .entry_pop   (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_data    (rsp_data)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.data  = rsp_data;

endmodule

// File: hw/rtl/msd_front.sv
module msd_front (
   input  logic                req_valid,
   input  msd_pkg::req_type   req_data,
   output logic                req_ready,
   input  logic                queue_ready,
   output logic                push,
   output msd_pkg::entry_type push_data
);
   import msd_pkg::*;

   logic        accepted;
   logic        in_range;
   logic [13:0] value;
   logic [27:0] prod_10;
   logic [27:0] prod_100;
   logic [27:0] prod_1000;

   // A beat is taken whenever the queue has room; the unused command is dropped.
   assign req_ready = queue_ready;
   assign accepted  = req_valid && queue_ready;
   assign push      = accepted && (req_data.cmd != CMD_UNUSED);

   // Numbers below zero or above the limit become the error text.
   assign in_range = !req_data.number[15] && (req_data.number[14:0] <= NUMBER_LIMIT);
   assign value    = req_data.number[13:0];

   // Decimal quotients by reciprocal multiplication; exact for values up to the limit.
   assign prod_10   = 28'(value) * 28'(RECIP_10);
   assign prod_100  = 28'(value) * 28'(RECIP_100);
   assign prod_1000 = 28'(value) * 28'(RECIP_1000);

   // Classify the command and build the queue entry.
   always_comb begin
      push_data.position  = req_data.position;
      push_data.character = req_data.character;
      push_data.value     = value;
      push_data.tens      = prod_10[SHIFT_10 +: 10];
      push_data.hundreds  = prod_100[SHIFT_100 +: 7];
      push_data.thousands = prod_1000[SHIFT_1000 +: 4];
      case (req_data.cmd)
         CMD_TICK:   push_data.op = OP_TICK;
         CMD_CHAR:   push_data.op = OP_CHAR;
         CMD_NUMBER: push_data.op = in_range ? OP_NUMBER : OP_ERROR;
         default:    push_data.op = OP_TICK;
      endcase
   end

endmodule

// File: hw/rtl/msd_queue.sv
module msd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  msd_pkg::entry_type push_data,
   output logic                push_ready,
   output logic                pop_valid,
   output msd_pkg::entry_type pop_data,
   input  logic                pop
);
   import msd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   entry_type        slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   // A push without a pop grows the fill by exactly one entry.
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill did not grow on push");

endmodule

// File: hw/rtl/msd_back.sv
module msd_back #(
   parameter int NUM_DIGITS = msd_pkg::DEFAULT_NUM_DIGITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                entry_valid,
   input  msd_pkg::entry_type entry,
   output logic                entry_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output msd_pkg::rsp_type   rsp_data
);
   import msd_pkg::*;

   localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic [IDX_W-1:0] LAST_DIGIT = IDX_W'(NUM_DIGITS - 1);

   logic [IDX_W-1:0] digit_cnt_ff, digit_cnt_in;
   logic [IDX_W-1:0] next_digit;
   logic [2:0]       next_wide;
   logic [7:0]       text_ff [NUM_DIGITS];
   logic [7:0]       text_in [NUM_DIGITS];
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             is_tick;
   logic             is_number;
   logic             out_free;
   logic [3:0]       dig_0, dig_1, dig_2, dig_3;
   logic [7:0]       num_char [MAX_DIGITS];
   logic [MAX_DIGITS-1:0] num_mask;

   // A tick waits for the output register; writes always drain.
   assign is_tick   = (entry.op == OP_TICK);
   assign is_number = (entry.op == OP_NUMBER) || (entry.op == OP_ERROR);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign entry_pop = entry_valid && (!is_tick || out_free);

   // Decimal digits from the quotients carried in the entry.
   assign dig_0 = 4'(entry.value - 14'(entry.tens) * 14'd10);
   assign dig_1 = 4'(entry.tens - 10'(entry.hundreds) * 10'd10);
   assign dig_2 = 4'(entry.hundreds - 7'(entry.thousands) * 7'd10);
   assign dig_3 = entry.thousands;

   // Left-aligned characters of a number, with a blank code after a short one.
   always_comb begin
      num_char = '{default: 8'h00};
      num_mask = '0;
      if (entry.op == OP_ERROR) begin
         num_char[0] = "F";
         num_char[1] = "E";
         num_char[2] = "H";
         num_char[3] = "L";
         num_mask[3:0] = 4'b1111;
      end else if (entry.value >= 14'd1000) begin
         num_char[0] = {4'h3, dig_3};
         num_char[1] = {4'h3, dig_2};
         num_char[2] = {4'h3, dig_1};
         num_char[3] = {4'h3, dig_0};
         num_mask[3:0] = 4'b1111;
      end else if (entry.value >= 14'd100) begin
         num_char[0] = {4'h3, dig_2};
         num_char[1] = {4'h3, dig_1};
         num_char[2] = {4'h3, dig_0};
         num_mask[3:0] = 4'b1111;
      end else if (entry.value >= 14'd10) begin
         num_char[0] = {4'h3, dig_1};
         num_char[1] = {4'h3, dig_0};
         num_mask[3:0] = 4'b0111;
      end else begin
         num_char[0] = {4'h3, dig_0};
         num_mask[3:0] = 4'b0011;
      end
   end

   // Text buffer writes; positions beyond the display are dropped.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         text_in[i] = text_ff[i];
         if (entry_pop && (entry.op == OP_CHAR) && (int'(entry.position) == i)) begin
            text_in[i] = entry.character;
         end
         if (entry_pop && is_number && num_mask[i]) begin
            text_in[i] = num_char[i];
         end
      end
   end

   // Digit advance and the result of a tick.
   assign next_digit = (digit_cnt_ff == LAST_DIGIT) ? '0 : digit_cnt_ff + 1'b1;
   assign next_wide  = 3'(next_digit);

   always_comb begin
      digit_cnt_in = digit_cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (entry_pop && is_tick) begin
         digit_cnt_in                = next_digit;
         rsp_valid_in                = 1'b1;
         rsp_data_in.digit_index     = next_wide[1:0];
         rsp_data_in.cathode_lines   = next_wide[2] ? 4'hF : ~(4'b0001 << next_wide[1:0]);
         rsp_data_in.segment_pattern = glyph(text_ff[next_digit]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_cnt_ff <= LAST_DIGIT;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            text_ff[i] <= reset_char(i);
         end
      end else begin
         digit_cnt_ff <= digit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         text_ff      <= text_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The digit counter never leaves the display.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      int'(digit_cnt_ff) < NUM_DIGITS)
      else $error("digit counter beyond the display");

   // A retired tick shows up as a result for the digit it selected.
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      entry_pop && is_tick |=> rsp_valid_ff &&
         rsp_data_ff.digit_index == $past(next_wide[1:0]))
      else $error("tick did not produce its result");

   // Character and number writes leave the digit counter alone.
   a_write_keeps_cnt: assert property (@(posedge clock) disable iff (reset)
      entry_pop && !is_tick |=> $stable(digit_cnt_ff))
      else $error("write moved the digit counter");

endmodule
